[rtl/core/log_band_peak_braille_unit_macros.svh]
// Assertion macros used by the log-band peak braille core.
`ifndef LOG_BAND_PEAK_BRAILLE_UNIT_MACROS_SVH
`define LOG_BAND_PEAK_BRAILLE_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LBPB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LBPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lbpb_pkg.sv]
// Types, constants and helper functions of the log-band peak braille core.
package lbpb_pkg;

    // Transform size and display limits
    localparam int FFT_SIZE  = 4096;
    localparam int MAX_CELLS = 64;

    localparam logic [15:0] HALF_FFT = 16'(FFT_SIZE / 2);
    localparam logic [6:0]  CELL_CAP = 7'(MAX_CELLS);

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_EDGE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_RATIO = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CELLS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_BIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DB     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DB     = 3'd5;

    // Register defaults
    localparam logic [31:0]        RESET_START_EDGE = 32'd11141120;
    localparam logic [31:0]        RESET_EDGE_RATIO = 32'd1122000000;
    localparam logic [6:0]         RESET_NUM_CELLS  = 7'd64;
    localparam logic [15:0]        RESET_LAST_BIN   = 16'd2048;
    localparam logic signed [15:0] RESET_MIN_DB     = -16'sd15360;
    localparam logic signed [15:0] RESET_MAX_DB     = 16'sd0;

    // Smallest edge growth factor, 1.0 in Q2.30
    localparam logic [31:0] RATIO_ONE = 32'h4000_0000;

    // Peak value at the start of a frame
    localparam logic signed [15:0] PEAK_FLOOR = 16'sh8000;

    // Bin queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0]        start_edge;
        logic [31:0]        edge_ratio;
        logic [6:0]         num_cells;
        logic [15:0]        last_bin;
        logic signed [15:0] min_db;
        logic signed [15:0] max_db;
    } cfg_t;

    // Classified bin word: level, position in the frame, frame end mark
    typedef struct packed {
        logic signed [15:0] bin_db;
        logic [15:0]        bin_idx;
        logic               frame_end;
    } bin_word_t;

    // Clamp the last bin to half the transform size
    function automatic logic [15:0] eff_last_f(input logic [15:0] lb);
        return (lb > HALF_FFT) ? HALF_FFT : lb;
    endfunction

    // Number of columns per frame, two per cell
    function automatic logic [7:0] eff_cols_f(input logic [6:0] nc);
        logic [6:0] c;
        c = nc;
        if (c == 7'd0)
        begin
            c = 7'd1;
        end
        if (c > CELL_CAP)
        begin
            c = CELL_CAP;
        end
        return {c, 1'b0};
    endfunction

    // Round a Q16.16 edge position to a bin and clamp it
    function automatic logic [15:0] edge_bin_f(input logic [31:0] pos, input logic [15:0] lb);
        logic [32:0] r;
        logic [16:0] b;
        r = {1'b0, pos} + 33'h0_0000_8000;
        b = r[32:16];
        return (b > {1'b0, lb}) ? lb : b[15:0];
    endfunction

    // Bar level 0..4 of a peak against the display floor and ceiling
    function automatic logic [2:0] level_f(
        input logic signed [15:0] peak,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [20:0] diff;
        logic signed [20:0] num;
        logic signed [20:0] span;
        logic signed [20:0] span3;
        logic [2:0]         lvl;
        diff  = 21'(peak) - 21'(lo);
        num   = (diff <<< 2) + diff;
        span  = 21'(hi) - 21'(lo);
        span3 = (span <<< 1) + span;
        lvl   = 3'd0;
        if (num >= span)
        begin
            lvl = lvl + 3'd1;
        end
        if (num >= (span <<< 1))
        begin
            lvl = lvl + 3'd1;
        end
        if (num >= span3)
        begin
            lvl = lvl + 3'd1;
        end
        if (num >= (span <<< 2))
        begin
            lvl = lvl + 3'd1;
        end
        return lvl;
    endfunction

    // Braille dot pattern of a left and a right bar
    function automatic logic [7:0] mask_f(input logic [2:0] left, input logic [2:0] right);
        logic [7:0] m;
        m    = 8'd0;
        m[0] = (left >= 3'd1);
        m[1] = (left >= 3'd2);
        m[2] = (left >= 3'd3);
        m[6] = (left >= 3'd4);
        m[3] = (right >= 3'd1);
        m[4] = (right >= 3'd2);
        m[5] = (right >= 3'd3);
        m[7] = (right >= 3'd4);
        return m;
    endfunction

    localparam logic [15:0] RESET_COL_START =
        edge_bin_f(RESET_START_EDGE, eff_last_f(RESET_LAST_BIN));

endpackage

[rtl/core/lbpb_if.sv]
// Valid/ready channels for spectrum bin words and braille cell words.
interface lbpb_bin_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] bin_db;

    modport source (output valid, output bin_db, input ready);
    modport sink   (input valid, input bin_db, output ready);
endinterface

interface lbpb_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_mask;
    logic [5:0] cell_index;
    logic       cell_last;

    modport source (output valid, output cell_mask, output cell_index, output cell_last,
                    input ready);
    modport sink   (input valid, input cell_mask, input cell_index, input cell_last,
                    output ready);
endinterface

[rtl/core/lbpb_front.sv]
// Front part: accepts bin words, tags frame position, queues them for the back part.
module lbpb_front
    import lbpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [15:0] last_bin,
    lbpb_bin_if.sink   bin_in,
    output logic       q_valid,
    output bin_word_t  q_word,
    input  logic       q_pop
);

    bin_word_t              mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [15:0]            bin_cnt_reg;
    logic [15:0]            lb;
    logic                   push;
    logic                   frame_end;
    bin_word_t              new_word;

    assign lb        = eff_last_f(last_bin);
    assign bin_in.ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push      = bin_in.valid && bin_in.ready;
    assign frame_end = (bin_cnt_reg >= lb);

    // Classify the incoming word by its place in the frame
    always_comb
    begin
        new_word.bin_db    = bin_in.bin_db;
        new_word.bin_idx   = bin_cnt_reg;
        new_word.frame_end = frame_end;
    end

    assign q_valid = (count_reg != '0);
    assign q_word  = mem[rd_ptr_reg];

    // Store queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= new_word;
        end
    end

    // Advance pointers, occupancy and the bin counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            bin_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg  <= wr_ptr_reg + 1'b1;
                bin_cnt_reg <= frame_end ? 16'd0 : bin_cnt_reg + 16'd1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/core/lbpb_back.sv]
// Back part: tracks column edges and peaks, closes columns and emits braille cells.
module lbpb_back
    import lbpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  bin_word_t  q_word,
    output logic       q_pop,
    lbpb_cell_if.source cell_out
);

    `include "log_band_peak_braille_unit_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;

    logic [1:0]         state_reg,     state_next;
    logic [7:0]         col_cnt_reg,   col_cnt_next;
    logic [31:0]        edge_pos_reg,  edge_pos_next;
    logic [15:0]        col_start_reg, col_start_next;
    logic signed [15:0] peak_reg,      peak_next;
    logic [2:0]         left_lvl_reg,  left_lvl_next;
    logic [63:0]        prod_reg,      prod_next;
    bin_word_t          cur_reg,       cur_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_mask_reg,  out_mask_next;
    logic [5:0]         out_index_reg, out_index_next;
    logic               out_last_reg,  out_last_next;

    logic [15:0] lb;
    logic [7:0]  cols;
    logic [31:0] ratio;
    logic [63:0] prod_now;
    logic [33:0] prod_hi;
    logic [31:0] npos;
    logic [15:0] end_bin;
    logic [2:0]  lvl;
    logic        cols_open;
    logic        hold_col;
    logic        out_free;
    logic        close;
    logic        emit;

    // Effective configuration
    assign lb    = eff_last_f(cfg.last_bin);
    assign cols  = eff_cols_f(cfg.num_cells);
    assign ratio = (cfg.edge_ratio < RATIO_ONE) ? RATIO_ONE : cfg.edge_ratio;

    // Next edge: multiply now, saturate and round from the registered product
    assign prod_now = edge_pos_reg * ratio;
    assign prod_hi  = prod_reg[63:30];
    assign npos     = (prod_hi[33:32] != 2'b00) ? 32'hFFFF_FFFF : prod_hi[31:0];
    assign end_bin  = edge_bin_f(npos, lb);

    assign lvl       = level_f(peak_reg, cfg.min_db, cfg.max_db);
    assign cols_open = (col_cnt_reg < cols);
    assign hold_col  = (end_bin > cur_reg.bin_idx) && (cur_reg.bin_idx < lb);
    assign out_free  = !out_valid_reg || cell_out.ready;
    assign close     = (state_reg == S_DEC) && cols_open && !hold_col
                       && (!col_cnt_reg[0] || out_free);
    assign emit      = close && col_cnt_reg[0];

    assign cell_out.valid      = out_valid_reg;
    assign cell_out.cell_mask  = out_mask_reg;
    assign cell_out.cell_index = out_index_reg;
    assign cell_out.cell_last  = out_last_reg;

    // Column sequencer
    always_comb
    begin
        state_next     = state_reg;
        col_cnt_next   = col_cnt_reg;
        edge_pos_next  = edge_pos_reg;
        col_start_next = col_start_reg;
        peak_next      = peak_reg;
        left_lvl_next  = left_lvl_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !cell_out.ready;
        out_mask_next  = out_mask_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the next word and fold it into the open column
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_word;
                    prod_next  = prod_now;
                    state_next = S_DEC;
                    if (cols_open && (q_word.bin_idx >= col_start_reg)
                        && ($signed(q_word.bin_db) > peak_reg))
                    begin
                        peak_next = q_word.bin_db;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = prod_now;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!cols_open || hold_col)
                begin
                    // Word done: restart the frame after its last bin
                    state_next = S_IDLE;
                    if (cur_reg.frame_end)
                    begin
                        col_cnt_next   = 8'd0;
                        edge_pos_next  = cfg.start_edge;
                        col_start_next = edge_bin_f(cfg.start_edge, lb);
                        peak_next      = PEAK_FLOOR;
                        left_lvl_next  = 3'd0;
                    end
                end
                else if (close)
                begin
                    // Close the column; a right column emits its cell
                    if (!col_cnt_reg[0])
                    begin
                        left_lvl_next = lvl;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_mask_next  = mask_f(left_lvl_reg, lvl);
                        out_index_next = col_cnt_reg[6:1];
                        out_last_next  = ((col_cnt_reg + 8'd1) == cols);
                    end
                    col_cnt_next   = col_cnt_reg + 8'd1;
                    edge_pos_next  = npos;
                    col_start_next = end_bin;
                    peak_next      = cur_reg.bin_db;
                    state_next     = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        cur_reg       <= cur_next;
        out_mask_reg  <= out_mask_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_cnt_reg   <= 8'd0;
            edge_pos_reg  <= RESET_START_EDGE;
            col_start_reg <= RESET_COL_START;
            peak_reg      <= PEAK_FLOOR;
            left_lvl_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_cnt_reg   <= col_cnt_next;
            edge_pos_reg  <= edge_pos_next;
            col_start_reg <= col_start_next;
            peak_reg      <= peak_next;
            left_lvl_reg  <= left_lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LBPB_ASSERT_NEXT(a_mul_then_dec, state_reg == S_MUL, state_reg == S_DEC, "edge product not used")
    `LBPB_ASSERT_NEXT(a_emit_loads, emit, out_valid_reg && (out_index_reg == $past(col_cnt_reg[6:1])), "cell not loaded")
    `LBPB_ASSERT_NEXT(a_close_counts, close, col_cnt_reg == ($past(col_cnt_reg) + 8'd1), "column count lost")
    `LBPB_ASSERT_ALWAYS(a_left_level, left_lvl_reg <= 3'd4, "left bar level out of range")

endmodule

[rtl/core/log_band_peak_braille_unit.sv]
// Top level of the log-band peak braille core: configuration registers and the two parts.
// The front queue holds 4. A bin word passes S_IDLE and S_DEC in the back part,
// plus S_MUL and S_DEC per column it closes (edge multiply, then round, compare and close).
// A cell reaches the output register in the cycle after its right column closes.
// Reset restores register defaults and starts a fresh frame; no clearing pass is needed.
module log_band_peak_braille_unit
    import lbpb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    lbpb_bin_if.sink               bin_in,
    lbpb_cell_if.source            cell_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    logic      q_valid;
    bin_word_t q_word;
    logic      q_pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_edge <= RESET_START_EDGE;
            cfg_reg.edge_ratio <= RESET_EDGE_RATIO;
            cfg_reg.num_cells  <= RESET_NUM_CELLS;
            cfg_reg.last_bin   <= RESET_LAST_BIN;
            cfg_reg.min_db     <= RESET_MIN_DB;
            cfg_reg.max_db     <= RESET_MAX_DB;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_EDGE: cfg_reg.start_edge <= cfg_data;
                CFG_EDGE_RATIO: cfg_reg.edge_ratio <= cfg_data;
                CFG_NUM_CELLS:  cfg_reg.num_cells  <= cfg_data[6:0];
                CFG_LAST_BIN:   cfg_reg.last_bin   <= cfg_data[15:0];
                CFG_MIN_DB:     cfg_reg.min_db     <= cfg_data[15:0];
                CFG_MAX_DB:     cfg_reg.max_db     <= cfg_data[15:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    lbpb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .last_bin (cfg_reg.last_bin),
        .bin_in   (bin_in),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop)
    );

    lbpb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .cell_out (cell_out)
    );

endmodule

[dv/tb_log_band_peak_braille_unit.sv]
// Self-checking testbench for the log-band peak braille unit: directed and random bin streams.
`timescale 1ns / 100ps

module tb_log_band_peak_braille_unit;
    import lbpb_pkg::*;

    // Cycles of silence to let the back part finish a word with no cell
    localparam int QUIET_CYCLES   = 300;
    // Cycles without any accepted word before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    // Longest wait for the last cells at the end of the run
    localparam int END_WAIT       = 20000;
    // Receiver hold-off that fills the bin queue
    localparam int HOLD_CYCLES    = 300;
    // Random bin words wanted after the directed part
    localparam int RANDOM_BINS    = 390;

    typedef struct packed {
        logic [7:0] mask;
        logic [5:0] cell_pos;
        logic       last_flag;
    } braille_cell_t;

    // Tracks the frame, predicts cells from accepted bins and checks delivered cells
    class braille_scoreboard;
        cfg_t               regs;
        logic [15:0]        bin_pos;
        logic [7:0]         col_pos;
        logic [31:0]        edge_at;
        logic [15:0]        col_first;
        logic signed [15:0] peak;
        logic [2:0]         left_bar;
        braille_cell_t      expected_cells[$];
        int                 errors;
        int                 bins_taken;
        int                 cells_checked;

        function new();
            regs.start_edge = RESET_START_EDGE;
            regs.edge_ratio = RESET_EDGE_RATIO;
            regs.num_cells  = RESET_NUM_CELLS;
            regs.last_bin   = RESET_LAST_BIN;
            regs.min_db     = RESET_MIN_DB;
            regs.max_db     = RESET_MAX_DB;
            errors          = 0;
            bins_taken      = 0;
            cells_checked   = 0;
            restart();
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_START_EDGE: regs.start_edge = data;
                CFG_EDGE_RATIO: regs.edge_ratio = data;
                CFG_NUM_CELLS:  regs.num_cells  = data[6:0];
                CFG_LAST_BIN:   regs.last_bin   = data[15:0];
                CFG_MIN_DB:     regs.min_db     = data[15:0];
                CFG_MAX_DB:     regs.max_db     = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] last_eff();
            int lb;
            lb = regs.last_bin;
            if (lb > FFT_SIZE / 2)
            begin
                lb = FFT_SIZE / 2;
            end
            return 16'(lb);
        endfunction

        function logic [7:0] column_total();
            int c;
            c = regs.num_cells;
            c = (c < 1) ? 1 : ((c > MAX_CELLS) ? MAX_CELLS : c);
            return 8'(2 * c);
        endfunction

        // Multiply an edge by the growth factor, never below 1.0, saturating
        function logic [31:0] grow_edge(logic [31:0] pos);
            logic [63:0] r;
            logic [63:0] p;
            r = (regs.edge_ratio < RATIO_ONE) ? 64'(RATIO_ONE) : 64'(regs.edge_ratio);
            p = (64'(pos) * r) >> 30;
            return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
        endfunction

        // Round a Q16.16 position to the nearest bin, clamped to the frame end
        function logic [15:0] bin_of(logic [31:0] pos);
            logic [63:0] b;
            logic [15:0] lb;
            b  = (64'(pos) + 64'h8000) >> 16;
            lb = last_eff();
            return (b > 64'(lb)) ? lb : b[15:0];
        endfunction

        function logic [2:0] bar_level(logic signed [15:0] p);
            longint num;
            longint span;
            logic [2:0] lvl;
            num  = 5 * (longint'(p) - longint'(regs.min_db));
            span = longint'(regs.max_db) - longint'(regs.min_db);
            lvl  = 3'd0;
            for (int j = 1; j <= 4; j++)
            begin
                if (num >= j * span)
                begin
                    lvl++;
                end
            end
            return lvl;
        endfunction

        function logic [7:0] dots(logic [2:0] l, logic [2:0] r);
            logic [7:0] m;
            m = 8'h00;
            if (l >= 3'd1) m |= 8'h01;
            if (l >= 3'd2) m |= 8'h02;
            if (l >= 3'd3) m |= 8'h04;
            if (l >= 3'd4) m |= 8'h40;
            if (r >= 3'd1) m |= 8'h08;
            if (r >= 3'd2) m |= 8'h10;
            if (r >= 3'd3) m |= 8'h20;
            if (r >= 3'd4) m |= 8'h80;
            return m;
        endfunction

        function void restart();
            bin_pos   = 16'd0;
            col_pos   = 8'd0;
            edge_at   = regs.start_edge;
            col_first = bin_of(regs.start_edge);
            peak      = PEAK_FLOOR;
            left_bar  = 3'd0;
        endfunction

        // Fold one accepted bin into the frame and queue the cells it completes
        function void note_bin(logic signed [15:0] v);
            logic [15:0]   b;
            logic [15:0]   lb;
            logic [7:0]    cols;
            logic [31:0]   npos;
            logic [15:0]   stop;
            logic [2:0]    lvl;
            braille_cell_t c;
            b    = bin_pos;
            lb   = last_eff();
            cols = column_total();
            bins_taken++;
            if (col_pos < cols && b >= col_first && v > peak)
            begin
                peak = v;
            end
            while (col_pos < cols)
            begin
                npos = grow_edge(edge_at);
                stop = bin_of(npos);
                if (stop > b && b < lb)
                begin
                    break;
                end
                lvl = bar_level(peak);
                if (!col_pos[0])
                begin
                    left_bar = lvl;
                end
                else
                begin
                    c.mask      = dots(left_bar, lvl);
                    c.cell_pos  = col_pos[6:1];
                    c.last_flag = (col_pos + 8'd1 == cols);
                    expected_cells = {expected_cells, c};
                end
                col_pos++;
                edge_at   = npos;
                col_first = stop;
                peak      = v;
            end
            if (b >= lb)
            begin
                restart();
            end
            else
            begin
                bin_pos = b + 16'd1;
            end
        endfunction

        function void check_cell(logic [7:0] m, logic [5:0] p, logic l);
            braille_cell_t want;
            cells_checked++;
            if (expected_cells.size() == 0)
            begin
                $error("cell word with none expected: mask %h index %0d last %0b", m, p, l);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (want.mask !== m)
            begin
                $error("cell_mask: expected %h, got %h", want.mask, m);
                errors++;
            end
            if (want.cell_pos !== p)
            begin
                $error("cell_index: expected %0d, got %0d", want.cell_pos, p);
                errors++;
            end
            if (want.last_flag !== l)
            begin
                $error("cell_last: expected %0b, got %0b", want.last_flag, l);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lbpb_bin_if  bin_ch ();
    lbpb_cell_if cell_ch ();

    braille_scoreboard board;
    cfg_t              cur;
    int                send_pct;
    int                stall_pct;
    bit                quiet;
    int                hold_request;
    int                settings_run;

    log_band_peak_braille_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_in    (bin_ch),
        .cell_out  (cell_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every cell word taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && cell_ch.valid && cell_ch.ready)
        begin
            board.check_cell(cell_ch.cell_mask, cell_ch.cell_index, cell_ch.cell_last);
        end
    end

    // End the run when words are outstanding but nothing moves
    initial
    begin
        int stuck;
        stuck = 0;
        forever
        begin
            @(posedge clk);
            if ((bin_ch.valid && bin_ch.ready) || (cell_ch.valid && cell_ch.ready))
            begin
                stuck = 0;
            end
            else if (board.pending() > 0 || bin_ch.valid)
            begin
                stuck++;
            end
            if (stuck >= WATCHDOG_LIMIT)
            begin
                $error("no word accepted for %0d cycles", stuck);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Drive the receiver ready: random stall bursts and an occasional long hold-off
    initial
    begin
        int hold_left;
        int stall_left;
        bit nxt;
        hold_left     = 0;
        stall_left    = 0;
        cell_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!rst_n)
            begin
                nxt = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                nxt        = 1'b0;
            end
            else
            begin
                nxt = 1'b1;
            end
            cell_ch.ready <= nxt;
        end
    end

    // Offer one bin word, maybe after a gap, and hold it until taken; ends at a falling edge
    task automatic push_bin(input logic signed [15:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 99) < send_pct)
        begin
            gap = $urandom_range(1, 18);
            bin_ch.valid  <= 1'b0;
            bin_ch.bin_db <= 16'($urandom());
            repeat (gap) @(negedge clk);
        end
        bin_ch.valid  <= 1'b1;
        bin_ch.bin_db <= v;
        do
        begin
            @(posedge clk);
        end
        while (!bin_ch.ready);
        board.note_bin(v);
        @(negedge clk);
    endtask

    // Write one register; the enable stays high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic apply_setting(input cfg_t s);
        cur = s;
        write_reg(CFG_START_EDGE, s.start_edge);
        write_reg(CFG_EDGE_RATIO, s.edge_ratio);
        write_reg(CFG_NUM_CELLS, 32'(s.num_cells));
        write_reg(CFG_LAST_BIN, 32'(s.last_bin));
        write_reg(CFG_MIN_DB, 32'(s.min_db));
        write_reg(CFG_MAX_DB, 32'(s.max_db));
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Drop valid, wait for every expected cell, then let the back part go quiet
    task automatic settle();
        bin_ch.valid <= 1'b0;
        while (board.pending() > 0) @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    function automatic cfg_t make_setting(
        input logic [31:0] se, input logic [31:0] er, input logic [6:0] nc,
        input logic [15:0] lb, input logic signed [15:0] lo, input logic signed [15:0] hi
    );
        cfg_t s;
        s.start_edge = se;
        s.edge_ratio = er;
        s.num_cells  = nc;
        s.last_bin   = lb;
        s.min_db     = lo;
        s.max_db     = hi;
        return s;
    endfunction

    // Mostly short frames with few cells; now and then the extremes
    function automatic cfg_t random_setting();
        cfg_t s;
        int   r;
        int   lo;
        int   hi;
        r = $urandom_range(0, 9);
        if (r < 6)      s.start_edge = $urandom_range(0, 8 << 16);
        else if (r < 8) s.start_edge = $urandom_range(0, 40 << 16);
        else if (r < 9) s.start_edge = 32'd0;
        else            s.start_edge = $urandom();
        r = $urandom_range(0, 19);
        if (r < 10)      s.edge_ratio = $urandom_range(32'h4000_0000, 32'h6000_0000);
        else if (r < 14) s.edge_ratio = $urandom_range(32'h4000_0000, 32'h8000_0000);
        else if (r < 17) s.edge_ratio = $urandom();
        else             s.edge_ratio = RATIO_ONE;
        r = $urandom_range(0, 9);
        if (r < 7)      s.num_cells = 7'($urandom_range(1, 6));
        else if (r < 9) s.num_cells = 7'($urandom_range(7, 16));
        else            s.num_cells = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 9);
        if (r < 7)      s.last_bin = 16'($urandom_range(1, 40));
        else if (r < 9) s.last_bin = 16'($urandom_range(41, 120));
        else            s.last_bin = 16'($urandom_range(0, 4));
        r  = $urandom_range(0, 9);
        lo = 0 - int'($urandom_range(0, 20000));
        if (r < 6)      hi = lo + int'($urandom_range(1, 20000));
        else if (r < 7) hi = lo;
        else if (r < 8) hi = lo - int'($urandom_range(1, 5000));
        else
        begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = int'($urandom_range(0, 65535)) - 32768;
        end
        s.min_db = 16'(lo);
        s.max_db = 16'(hi);
        return s;
    endfunction

    // Bin level around the display range, on the level thresholds, or anywhere
    function automatic logic signed [15:0] pick_bin();
        int lo;
        int hi;
        int margin;
        int v;
        lo = cur.min_db;
        hi = cur.max_db;
        if (lo > hi)
        begin
            v  = lo;
            lo = hi;
            hi = v;
        end
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = $urandom_range(0, 1) ? 32767 : -32768;
            2, 3: v = lo + ((hi - lo) * int'($urandom_range(0, 5))) / 5
                      + int'($urandom_range(0, 2)) - 1;
            default:
            begin
                margin = (hi - lo) / 4 + 8;
                v = lo - margin + int'($urandom_range(0, hi - lo + 2 * margin));
            end
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    initial
    begin
        int random_bins;
        int n;
        int waited;
        board          = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        bin_ch.valid   = 1'b0;
        bin_ch.bin_db  = '0;
        send_pct       = 10;
        stall_pct      = 10;
        quiet          = 1'b0;
        hold_request   = 0;
        settings_run   = 0;
        random_bins    = 0;
        cur            = board.regs;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset values: every bin lies below the first edge, so nothing comes out
        push_bin(-16'sd32768);
        push_bin(16'sd32767);
        push_bin(16'sd0);
        push_bin(-16'sd1);
        push_bin(16'sh7F00);
        push_bin(-16'sd15360);
        settle();

        // Lower the frame end below the bin count: the next bin closes every column.
        // The new frame starts at edge zero, so all columns close on bin zero; cell
        // count above the cap, ratio below one, widest display range.
        apply_setting(make_setting(32'd0, 32'd0, 7'd127, 16'd4, -16'sd32768, 16'sd32767));
        push_bin(16'sd32767);
        push_bin(-16'sd32768);
        push_bin(16'sd12345);
        push_bin(-16'sd1);
        push_bin(16'sd0);
        push_bin(16'sd1);
        push_bin(16'sd32767);
        settle();

        // One-bin frames, zero cells acting as one, edges clamped, floor equal to ceiling
        apply_setting(make_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, 16'd0, 16'sd0, 16'sd0));
        push_bin(16'sd0);
        push_bin(-16'sd1);
        push_bin(16'sd1);
        push_bin(-16'sd32768);
        push_bin(16'sd32767);
        settle();

        // Ceiling below floor
        apply_setting(make_setting(32'h0002_0000, 32'h6000_0000, 7'd2, 16'd12,
                                   16'sd256, -16'sd256));
        push_bin(16'sd300);
        push_bin(-16'sd300);
        push_bin(16'sd32767);
        push_bin(16'sd0);
        push_bin(16'sd256);
        push_bin(-16'sd256);
        push_bin(-16'sd32768);
        settle();

        // Receiver holds off while bins keep coming, so the queue fills and stalls input
        send_pct  = 0;
        stall_pct = 10;
        apply_setting(make_setting(32'h0001_0000, 32'h5000_0000, 7'd4, 16'd20,
                                   -16'sd10000, 16'sd0));
        hold_request = HOLD_CYCLES;
        repeat (40) push_bin(pick_bin());
        settle();

        // Random settings and bins; the tail runs without any idling
        while (random_bins < RANDOM_BINS)
        begin
            if (random_bins >= RANDOM_BINS - 80)
            begin
                quiet = 1'b1;
            end
            case ($urandom_range(0, 3))
                0: send_pct = 0;
                1: send_pct = 5;
                2: send_pct = 15;
                default: send_pct = 35;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 5;
                2: stall_pct = 15;
                default: stall_pct = 35;
            endcase
            apply_setting(random_setting());
            n = $urandom_range(25, 50);
            repeat (n) push_bin(pick_bin());
            random_bins += n;
            bin_ch.valid <= 1'b0;
            while (board.pending() > 0) @(negedge clk);
            repeat (QUIET_CYCLES) @(negedge clk);
        end

        // Wait out the last cells, then look for stray ones
        waited = 0;
        while (board.pending() > 0 && waited < END_WAIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (QUIET_CYCLES) @(negedge clk);
        if (board.pending() > 0)
        begin
            $error("%0d expected cells never arrived", board.pending());
            board.errors += board.pending();
        end

        $display("Run: %0d bin words over %0d register settings, %0d cell words checked.",
                 board.bins_taken, settings_run, board.cells_checked);
        $display("Included edge clamps, mid-frame frame-end changes and a long stalled receiver.");
        if (board.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/lbpb_pkg.sv
rtl/core/lbpb_if.sv
rtl/core/lbpb_front.sv
rtl/core/lbpb_back.sv
rtl/core/log_band_peak_braille_unit.sv
dv/tb_log_band_peak_braille_unit.sv
